### rtl/ile_pkg.sv
package ile_pkg;

   localparam int CAPACITY = 256;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int MODE_W   = 3;
   localparam int POS_W    = 10;
   localparam int VAL_W    = 32;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [MODE_W-1:0] MODE_READ     = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_INS_HEAD = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_INS_TAIL = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_INS_AT   = MODE_W'(3);
   localparam logic [MODE_W-1:0] MODE_DELETE   = MODE_W'(4);

   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ALLOC,
      S_WALK,
      S_INS_HEAD,
      S_INS_LINK,
      S_INS_FIX,
      S_DEL_HEAD,
      S_DEL_RD,
      S_DEL_FIX,
      S_RESP
   } ile_state_type;

   typedef enum logic [1:0] {
      OP_READ,
      OP_INS,
      OP_DEL
   } ile_op_type;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_READ_HIT,
      RES_READ_MISS,
      RES_HIT,
      RES_DROP
   } ile_res_type;

   typedef struct packed {
      logic        accept;
      logic        walk_init;
      logic        alloc;
      logic        alloc_capture;
      logic        walk;
      logic        ins_head;
      logic        ins_link;
      logic        ins_fix;
      logic        del_head;
      logic        del_read;
      logic        del_fix;
      logic        resp_load;
      ile_res_type res;
   } ile_cmd_type;

   typedef struct packed {
      logic is_read;
      logic is_ins;
      logic is_del;
      logic in_range;
      logic ins_ok;
      logic full;
      logic k_zero;
      logic hops_zero;
      logic rsp_busy;
   } ile_status_type;

endpackage

### rtl/ile_ctrl.sv
module ile_ctrl
   import ile_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  ile_status_type st,
   output ile_cmd_type    cmd
);

   ile_state_type state_ff, state_in;
   ile_op_type    op_ff, op_in;
   ile_res_type   res_ff, res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_READ;
         res_ff   <= RES_NONE;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         res_ff   <= res_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      res_in   = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            res_in   = RES_NONE;
            state_in = S_RESP;
            if (st.is_read) begin
               if (st.in_range) begin
                  op_in    = OP_READ;
                  state_in = S_WALK;
               end else begin
                  res_in = RES_READ_MISS;
               end
            end else if (st.is_ins) begin
               if (st.ins_ok && st.full) begin
                  res_in = RES_DROP;
               end else if (st.ins_ok) begin
                  op_in    = OP_INS;
                  state_in = S_ALLOC;
               end
            end else if (st.is_del && st.in_range) begin
               op_in    = OP_DEL;
               state_in = S_WALK;
            end
         end
         S_ALLOC: begin
            state_in = st.k_zero ? S_INS_HEAD : S_WALK;
         end
         S_WALK: begin
            if (st.hops_zero) begin
               case (op_ff)
                  OP_READ: begin
                     res_in   = RES_READ_HIT;
                     state_in = S_RESP;
                  end
                  OP_INS:  state_in = S_INS_LINK;
                  OP_DEL:  state_in = st.k_zero ? S_DEL_HEAD : S_DEL_RD;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_INS_HEAD: begin
            res_in   = RES_HIT;
            state_in = S_RESP;
         end
         S_INS_LINK: state_in = S_INS_FIX;
         S_INS_FIX: begin
            res_in   = RES_HIT;
            state_in = S_RESP;
         end
         S_DEL_HEAD: begin
            res_in   = RES_HIT;
            state_in = S_RESP;
         end
         S_DEL_RD: state_in = S_DEL_FIX;
         S_DEL_FIX: begin
            res_in   = RES_HIT;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!st.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.res   = res_ff;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE:     cmd.accept = req_valid;
         S_DECODE: begin
            cmd.walk_init = 1'b1;
            cmd.alloc     = st.is_ins && st.ins_ok && !st.full;
         end
         S_ALLOC:    cmd.alloc_capture = 1'b1;
         S_WALK:     cmd.walk = 1'b1;
         S_INS_HEAD: cmd.ins_head = 1'b1;
         S_INS_LINK: cmd.ins_link = 1'b1;
         S_INS_FIX:  cmd.ins_fix = 1'b1;
         S_DEL_HEAD: cmd.del_head = 1'b1;
         S_DEL_RD:   cmd.del_read = 1'b1;
         S_DEL_FIX:  cmd.del_fix = 1'b1;
         S_RESP:     cmd.resp_load = !st.rsp_busy;
         default:    cmd = '0;
      endcase
   end

endmodule

### rtl/ile_dpath.sv
module ile_dpath
   import ile_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  ile_cmd_type             cmd,
   output ile_status_type          st,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic signed [POS_W-1:0] req_position,
   input  logic signed [VAL_W-1:0] req_item_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic                    rsp_hit,
   output logic                    rsp_full_drop,
   output logic [CNT_W-1:0]        rsp_count_now
);

   logic [VAL_W-1:0]  value_mem [CAPACITY];
   logic [SLOT_W-1:0] link_mem  [CAPACITY];
   logic [SLOT_W-1:0] free_mem  [CAPACITY];

   logic [VAL_W-1:0]  value_q;
   logic [SLOT_W-1:0] link_q;
   logic [SLOT_W-1:0] free_q;

   logic [MODE_W-1:0] mode_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [VAL_W-1:0]  val_ff;

   logic [SLOT_W-1:0] head_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  fsp_ff;
   logic [CNT_W-1:0]  hw_ff;

   logic [SLOT_W-1:0] cur_ff;
   logic [SLOT_W-1:0] new_ff;
   logic [SLOT_W-1:0] victim_ff;
   logic [CNT_W-1:0]  hops_ff;
   logic              follow_ff;
   logic              use_stack_ff;

   logic              rsp_valid_ff;
   logic [VAL_W-1:0]  rsp_value_ff;
   logic              rsp_hit_ff;
   logic              rsp_drop_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   logic              pos_neg;
   logic [CMP_W-1:0]  pos_mag;
   logic [CMP_W-1:0]  count_ext;
   logic              le_count;
   logic [CNT_W-1:0]  eff_k;
   logic [CNT_W-1:0]  hops_init;
   logic [SLOT_W-1:0] cur_sel;
   logic              push;
   logic [SLOT_W-1:0] push_slot;
   logic              link_we;
   logic [SLOT_W-1:0] link_waddr;
   logic [SLOT_W-1:0] link_wdata;
   logic              link_re;
   logic [SLOT_W-1:0] link_raddr;

   // request decode
   always_comb begin
      pos_neg   = pos_ff[POS_W-1];
      pos_mag   = CMP_W'(pos_ff[POS_W-2:0]);
      count_ext = CMP_W'(count_ff);
      le_count  = !pos_neg && (pos_mag <= count_ext);

      st.is_read  = (mode_ff == MODE_READ);
      st.is_ins   = mode_ff inside {MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_AT};
      st.is_del   = (mode_ff == MODE_DELETE);
      st.in_range = !pos_neg && (pos_mag < count_ext);
      st.full     = (count_ff == CNT_W'(CAPACITY));

      case (mode_ff)
         MODE_INS_HEAD: begin
            eff_k     = '0;
            st.ins_ok = 1'b1;
         end
         MODE_INS_TAIL: begin
            eff_k     = count_ff;
            st.ins_ok = 1'b1;
         end
         MODE_INS_AT: begin
            eff_k     = pos_neg ? '0 : CNT_W'(pos_mag);
            st.ins_ok = pos_neg || le_count;
         end
         default: begin
            eff_k     = CNT_W'(pos_mag);
            st.ins_ok = 1'b0;
         end
      endcase

      st.k_zero = (eff_k == '0);
      // a read walks to the entry itself, an edit walks to its predecessor
      hops_init = (st.k_zero || st.is_read) ? eff_k : eff_k - CNT_W'(1);
      st.hops_zero = (hops_ff == '0);
      st.rsp_busy  = rsp_valid_ff && rsp_stall;
   end

   assign cur_sel = follow_ff ? link_q : cur_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_mode;
         pos_ff  <= req_position;
         val_ff  <= req_item_value;
      end
      if (cmd.walk_init) begin
         cur_ff    <= head_ff;
         follow_ff <= 1'b0;
         hops_ff   <= hops_init;
      end
      if (cmd.alloc) begin
         use_stack_ff <= (fsp_ff != '0);
         if (fsp_ff == '0) new_ff <= hw_ff[SLOT_W-1:0];
      end
      if (cmd.alloc_capture && use_stack_ff) new_ff <= free_q;
      if (cmd.walk) begin
         cur_ff <= cur_sel;
         if (hops_ff != '0) begin
            hops_ff   <= hops_ff - CNT_W'(1);
            follow_ff <= 1'b1;
         end else begin
            follow_ff <= 1'b0;
         end
      end
      if (cmd.del_read) victim_ff <= link_q;
   end

   // list head, entry count and free slot bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         fsp_ff   <= '0;
         hw_ff    <= '0;
      end else begin
         if (cmd.alloc) begin
            if (fsp_ff != '0) fsp_ff <= fsp_ff - CNT_W'(1);
            else              hw_ff  <= hw_ff + CNT_W'(1);
         end
         if (cmd.ins_head) head_ff <= new_ff;
         if (cmd.del_head) head_ff <= link_q;
         if (cmd.ins_head || cmd.ins_fix) count_ff <= count_ff + CNT_W'(1);
         if (cmd.del_head || cmd.del_fix) begin
            count_ff <= count_ff - CNT_W'(1);
            fsp_ff   <= fsp_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_head || cmd.ins_link) value_mem[new_ff] <= val_ff;
      if (cmd.walk) value_q <= value_mem[cur_sel];
   end

   always_comb begin
      link_we    = cmd.ins_head || cmd.ins_link || cmd.ins_fix || cmd.del_fix;
      link_waddr = (cmd.ins_fix || cmd.del_fix) ? cur_ff : new_ff;
      if (cmd.ins_head)     link_wdata = head_ff;
      else if (cmd.ins_fix) link_wdata = new_ff;
      else                  link_wdata = link_q;
      link_re    = cmd.walk || cmd.del_read;
      link_raddr = cmd.del_read ? link_q : cur_sel;
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      if (link_re) link_q <= link_mem[link_raddr];
   end

   // free stack: entries below fsp_ff hold released slots
   assign push      = cmd.del_head || cmd.del_fix;
   assign push_slot = cmd.del_head ? cur_ff : victim_ff;

   always_ff @(posedge clock) begin
      if (push) free_mem[fsp_ff[SLOT_W-1:0]] <= push_slot;
      if (cmd.alloc && (fsp_ff != '0)) begin
         free_q <= free_mem[fsp_ff[SLOT_W-1:0] - SLOT_W'(1)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.resp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         rsp_count_ff <= count_ff;
         rsp_value_ff <= '0;
         rsp_hit_ff   <= 1'b0;
         rsp_drop_ff  <= 1'b0;
         case (cmd.res)
            RES_READ_HIT: begin
               rsp_value_ff <= value_q;
               rsp_hit_ff   <= 1'b1;
            end
            RES_READ_MISS: rsp_value_ff <= MISS_VALUE;
            RES_HIT:       rsp_hit_ff   <= 1'b1;
            RES_DROP:      rsp_drop_ff  <= 1'b1;
            default:       rsp_hit_ff   <= 1'b0;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_full_drop  = rsp_drop_ff;
   assign rsp_count_now  = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> ((CNT_W+1)'(count_ff) + (CNT_W+1)'(fsp_ff)) == (CNT_W+1)'(hw_ff))
      else $error("live plus free slots do not match slots handed out");

   a_alloc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> (count_ff != CNT_W'(CAPACITY)) && ((fsp_ff != '0) || (hw_ff != CNT_W'(CAPACITY))))
      else $error("slot allocated with no slot left");

   a_resp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

endmodule

### rtl/indexed_list_engine_top.sv
// Ordered list of up to CAPACITY signed 32-bit values kept as linked slots.
// Each request returns exactly one result item. The block takes one request
// at a time. A miss, a drop or an ignored position needs no walk, nor does
// an insert at the head; other reads, deletes and inserts walk the list
// from the head, following one link per cycle through the link memory. A
// tail insert into a list one short of full is the slowest case.
// A finished request waits in place while the previous result is still
// stalled. No clearing pass runs after reset: released slots go to a free
// stack and fresh slots come from a high-water counter, so the block takes
// requests from the first cycle. A new request is accepted while the
// previous result still waits to be taken; a full list drops inserts and
// reports full_drop.
module indexed_list_engine_top
   import ile_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic signed [POS_W-1:0] req_position,
   input  logic signed [VAL_W-1:0] req_item_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic                    rsp_hit,
   output logic                    rsp_full_drop,
   output logic [CNT_W-1:0]        rsp_count_now
);

   ile_cmd_type    cmd;
   ile_status_type st;

   ile_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   ile_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_mode       (req_mode),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_hit        (rsp_hit),
      .rsp_full_drop  (rsp_full_drop),
      .rsp_count_now  (rsp_count_now)
   );

endmodule
